/* design/tpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

  // default converter resolution
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // pressure gate
  localparam int unsigned PRESS_THRESH = 100;

  // register reset values for the screen size
  localparam int unsigned SCREEN_W_RST = 320;
  localparam int unsigned SCREEN_H_RST = 240;

  // divider pipeline: quotient bits are split evenly over these stages
  localparam int unsigned DIV_STAGES = 3;
  // lane depth: operand stage, product stage, divider stages
  localparam int unsigned LANE_DEPTH = DIV_STAGES + 2;

  // APB register map, one word per register
  localparam int unsigned PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_X_CAL_MIN = 3'd0,
    REG_X_CAL_MAX = 3'd1,
    REG_Y_CAL_MIN = 3'd2,
    REG_Y_CAL_MAX = 3'd3,
    REG_SCREEN_W  = 3'd4,
    REG_SCREEN_H  = 3'd5,
    REG_INVERT_X  = 3'd6,
    REG_INVERT_Y  = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

/* design/tpc_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module tpc_regs import tpc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready,
  output logic      [SAMPLE_BITS-1:0] x_cal_min_o,
  output logic      [SAMPLE_BITS-1:0] x_cal_max_o,
  output logic      [SAMPLE_BITS-1:0] y_cal_min_o,
  output logic      [SAMPLE_BITS-1:0] y_cal_max_o,
  output logic      [SAMPLE_BITS-1:0] screen_width_o,
  output logic      [SAMPLE_BITS-1:0] screen_height_o,
  output logic                        invert_x_o,
  output logic                        invert_y_o
);

  localparam int unsigned N = SAMPLE_BITS;

  logic [N-1:0] x_cal_min_q, x_cal_max_q, y_cal_min_q, y_cal_max_q;
  logic [N-1:0] screen_width_q, screen_height_q;
  logic         invert_x_q, invert_y_q;
  reg_idx_e     idx;
  logic         wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_cal_min_q     <= '0;
      x_cal_max_q     <= '1;
      y_cal_min_q     <= '0;
      y_cal_max_q     <= '1;
      screen_width_q  <= N'(SCREEN_W_RST);
      screen_height_q <= N'(SCREEN_H_RST);
      invert_x_q      <= 1'b0;
      invert_y_q      <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_X_CAL_MIN: x_cal_min_q     <= pwdata[N-1:0];
        REG_X_CAL_MAX: x_cal_max_q     <= pwdata[N-1:0];
        REG_Y_CAL_MIN: y_cal_min_q     <= pwdata[N-1:0];
        REG_Y_CAL_MAX: y_cal_max_q     <= pwdata[N-1:0];
        REG_SCREEN_W:  screen_width_q  <= pwdata[N-1:0];
        REG_SCREEN_H:  screen_height_q <= pwdata[N-1:0];
        REG_INVERT_X:  invert_x_q      <= pwdata[0];
        REG_INVERT_Y:  invert_y_q      <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_X_CAL_MIN: prdata = 32'(x_cal_min_q);
      REG_X_CAL_MAX: prdata = 32'(x_cal_max_q);
      REG_Y_CAL_MIN: prdata = 32'(y_cal_min_q);
      REG_Y_CAL_MAX: prdata = 32'(y_cal_max_q);
      REG_SCREEN_W:  prdata = 32'(screen_width_q);
      REG_SCREEN_H:  prdata = 32'(screen_height_q);
      REG_INVERT_X:  prdata = 32'(invert_x_q);
      REG_INVERT_Y:  prdata = 32'(invert_y_q);
      default:       prdata = '0;
    endcase
  end

  assign x_cal_min_o     = x_cal_min_q;
  assign x_cal_max_o     = x_cal_max_q;
  assign y_cal_min_o     = y_cal_min_q;
  assign y_cal_max_o     = y_cal_max_q;
  assign screen_width_o  = screen_width_q;
  assign screen_height_o = screen_height_q;
  assign invert_x_o      = invert_x_q;
  assign invert_y_o      = invert_y_q;

endmodule

`default_nettype wire

/* design/tpc_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

// One axis: invert, offset, scale by screen size, divide by calibration span, clamp.
module tpc_lane import tpc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic [SAMPLE_BITS-1:0] raw_i,
  input  wire logic                   invert_i,
  input  wire logic [SAMPLE_BITS-1:0] cal_lo_i,
  input  wire logic [SAMPLE_BITS-1:0] cal_hi_i,
  input  wire logic [SAMPLE_BITS-1:0] size_i,
  output logic                        valid_o,
  output logic      [SAMPLE_BITS-1:0] pos_o
);

  localparam int unsigned N   = SAMPLE_BITS;
  localparam int unsigned BPS = (N + DIV_STAGES - 1) / DIV_STAGES;
  localparam int unsigned QW  = BPS * DIV_STAGES;
  localparam int unsigned RX  = N + QW;

  // ---------------- operand stage ----------------
  logic [N-1:0] mx;
  logic [N:0]   diff, span, ndiff, nspan;
  logic [N-1:0] a_absd_q, a_abssp_q, a_size_q;
  logic         a_neg_q, a_zsp_q, a_vld_q;

  assign mx    = invert_i ? ~raw_i : raw_i;
  assign diff  = {1'b0, mx} - {1'b0, cal_lo_i};
  assign span  = {1'b0, cal_hi_i} - {1'b0, cal_lo_i};
  assign ndiff = -diff;
  assign nspan = -span;

  always_ff @(posedge clk_i) begin
    a_absd_q  <= diff[N] ? ndiff[N-1:0] : diff[N-1:0];
    a_abssp_q <= span[N] ? nspan[N-1:0] : span[N-1:0];
    a_neg_q   <= diff[N] ^ span[N];
    a_zsp_q   <= (cal_lo_i == cal_hi_i);
    a_size_q  <= size_i;
  end

  // ---------------- product stage and divider state ----------------
  logic [2*N-1:0] prod;
  logic           ovf;

  logic [RX-1:0] rem_q [DIV_STAGES];
  logic [N-1:0]  div_q [DIV_STAGES];
  logic [QW-1:0] quo_q [1:DIV_STAGES];
  logic [N-1:0]  size_q [DIV_STAGES+1];
  logic          neg_q [DIV_STAGES+1];
  logic          zsp_q [DIV_STAGES+1];
  logic          ovf_q [DIV_STAGES+1];
  logic          vld_q [DIV_STAGES+1];

  assign prod = (2*N)'(a_absd_q) * (2*N)'(a_size_q);
  // quotient would not fit in N bits: saturates to size
  assign ovf  = prod >= {a_abssp_q, {N{1'b0}}};

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RX'(prod);
    div_q[0]  <= a_abssp_q;
    size_q[0] <= a_size_q;
    neg_q[0]  <= a_neg_q;
    zsp_q[0]  <= a_zsp_q;
    ovf_q[0]  <= ovf;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      a_vld_q  <= valid_i;
      vld_q[0] <= a_vld_q;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------- restoring divider, BPS quotient bits per stage ----------------
  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    logic [QW-1:0] quo_in;
    logic [RX-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (s == 1) begin : g_first
      assign quo_in = '0;
    end else begin : g_next
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [RX-1:0] dsh;
      rem_d = rem_q[s-1];
      quo_d = quo_in;
      for (int j = 0; j < BPS; j++) begin
        dsh = RX'(div_q[s-1]) << (QW - 1 - ((s - 1) * BPS + j));
        if (rem_d >= dsh) begin
          rem_d = rem_d - dsh;
          quo_d[QW - 1 - ((s - 1) * BPS + j)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s]  <= quo_d;
      size_q[s] <= size_q[s-1];
      neg_q[s]  <= neg_q[s-1];
      zsp_q[s]  <= zsp_q[s-1];
      ovf_q[s]  <= ovf_q[s-1];
    end

    if (s < DIV_STAGES) begin : g_fwd
      always_ff @(posedge clk_i) begin
        rem_q[s] <= rem_d;
        div_q[s] <= div_q[s-1];
      end
    end
  end

  // ---------------- clamp ----------------
  logic sat;
  assign sat     = ovf_q[DIV_STAGES] | (quo_q[DIV_STAGES] > QW'(size_q[DIV_STAGES]));
  assign valid_o = vld_q[DIV_STAGES];

  always_comb begin
    priority if (zsp_q[DIV_STAGES] || neg_q[DIV_STAGES]) begin
      pos_o = '0;
    end else if (sat) begin
      pos_o = size_q[DIV_STAGES];
    end else begin
      pos_o = quo_q[DIV_STAGES][N-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/touch_pressure_calibrate_map.sv */
// Pipeline: a request accepted at a clock edge passes the operand stage, product stage,
// three divider stages and merge register before its result shows.
// Throughput: one request per cycle; busy is never raised, and the result
// strobe is a single cycle that the receiver cannot stall.
// Reset: rst_ni clears the pipeline valids and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module touch_pressure_calibrate_map import tpc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // request
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [SAMPLE_BITS-1:0] z1_reading_i,
  input  wire logic [SAMPLE_BITS-1:0] z2_reading_i,
  input  wire logic [SAMPLE_BITS-1:0] x_reading_i,
  input  wire logic [SAMPLE_BITS-1:0] y_reading_i,
  // result
  output logic                        res_valid_o,
  output logic      [SAMPLE_BITS-1:0] pos_x_o,
  output logic      [SAMPLE_BITS-1:0] pos_y_o,
  output logic      [SAMPLE_BITS-1:0] raw_x_out_o,
  output logic      [SAMPLE_BITS-1:0] raw_y_out_o,
  output logic      [SAMPLE_BITS:0]   pressure_out_o,
  output logic                        touched_o,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);

  localparam int unsigned N = SAMPLE_BITS;

  logic         accept;
  logic [N-1:0] x_cal_min, x_cal_max, y_cal_min, y_cal_max;
  logic [N-1:0] screen_width, screen_height;
  logic         invert_x, invert_y;
  logic         lx_valid, ly_valid;
  logic [N-1:0] lx_pos, ly_pos;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  tpc_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .x_cal_min_o     (x_cal_min),
    .x_cal_max_o     (x_cal_max),
    .y_cal_min_o     (y_cal_min),
    .y_cal_max_o     (y_cal_max),
    .screen_width_o  (screen_width),
    .screen_height_o (screen_height),
    .invert_x_o      (invert_x),
    .invert_y_o      (invert_y)
  );

  // x and y lanes
  tpc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .raw_i    (x_reading_i),
    .invert_i (invert_x),
    .cal_lo_i (x_cal_min),
    .cal_hi_i (x_cal_max),
    .size_i   (screen_width),
    .valid_o  (lx_valid),
    .pos_o    (lx_pos)
  );

  tpc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .raw_i    (y_reading_i),
    .invert_i (invert_y),
    .cal_lo_i (y_cal_min),
    .cal_hi_i (y_cal_max),
    .size_i   (screen_height),
    .valid_o  (ly_valid),
    .pos_o    (ly_pos)
  );

  // pressure and raw readings ride alongside the lanes
  logic [N:0]   press;
  logic [N-1:0] rx_sq [LANE_DEPTH];
  logic [N-1:0] ry_sq [LANE_DEPTH];
  logic [N:0]   pr_sq [LANE_DEPTH];

  assign press = {1'b0, z1_reading_i} + {1'b0, {N{1'b1}}} - {1'b0, z2_reading_i};

  always_ff @(posedge clk_i) begin
    rx_sq[0] <= x_reading_i;
    ry_sq[0] <= y_reading_i;
    pr_sq[0] <= press;
    for (int k = 1; k < LANE_DEPTH; k++) begin
      rx_sq[k] <= rx_sq[k-1];
      ry_sq[k] <= ry_sq[k-1];
      pr_sq[k] <= pr_sq[k-1];
    end
  end

  // merge: pressure gate over both lanes
  logic         touch;
  logic         res_valid_q;
  logic [N-1:0] pos_x_q, pos_y_q, raw_x_q, raw_y_q;
  logic [N:0]   press_q;
  logic         touched_q;

  assign touch = pr_sq[LANE_DEPTH-1] >= (N+1)'(PRESS_THRESH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= lx_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q   <= touch ? lx_pos : '0;
    pos_y_q   <= touch ? ly_pos : '0;
    raw_x_q   <= touch ? rx_sq[LANE_DEPTH-1] : '0;
    raw_y_q   <= touch ? ry_sq[LANE_DEPTH-1] : '0;
    press_q   <= touch ? pr_sq[LANE_DEPTH-1] : '0;
    touched_q <= touch;
  end

  assign res_valid_o    = res_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign raw_x_out_o    = raw_x_q;
  assign raw_y_out_o    = raw_y_q;
  assign pressure_out_o = press_q;
  assign touched_o      = touched_q;

  // lanes stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lx_valid == ly_valid)
    else $error("x and y lanes out of step");

  // every request gives exactly one result at the pipeline output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 res_valid_o)
    else $error("result missing after request");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, 6))
    else $error("result without request");

  // no touch clears the whole result
  a_untouched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !touched_o) |->
      (pos_x_o == '0 && pos_y_o == '0 && raw_x_out_o == '0 &&
       raw_y_out_o == '0 && pressure_out_o == '0))
    else $error("untouched result not cleared");

endmodule

`default_nettype wire
